>>> design/lcm_pkg.sv
`default_nettype none
package lcm_pkg;

    // one input word
    typedef struct packed {
        logic        start_of_cloud;
        logic [31:0] label;
        logic [31:0] coord_x;
        logic [31:0] coord_y;
        logic [31:0] coord_z;
    } t_in_word;

    // one result word
    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        table_full;
    } t_out_word;

    // classified word handed from the front to the back
    typedef struct packed {
        logic        start_of_cloud;
        logic        is_unlabeled;
        logic [31:0] label;
        logic [31:0] coord_x;
        logic [31:0] coord_y;
        logic [31:0] coord_z;
    } t_item;

    localparam int HUE_W = 9;
    localparam logic [HUE_W-1:0] HUE_STEP = 9'd77;
    localparam logic [HUE_W:0]   HUE_WRAP = 10'd360;
    localparam logic [5:0]       SECTOR_SPAN = 6'd60;

endpackage
`default_nettype wire

>>> design/lcm_front.sv
`default_nettype none
module lcm_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire lcm_pkg::t_in_word i_data,
    output logic                   o_push,
    input  wire logic              i_push_ready,
    output lcm_pkg::t_item         o_item
);

    logic           r_valid;
    lcm_pkg::t_item r_item;

    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.start_of_cloud <= i_data.start_of_cloud;
            r_item.is_unlabeled   <= (i_data.label == 32'd0);
            r_item.label          <= i_data.label;
            r_item.coord_x        <= i_data.coord_x;
            r_item.coord_y        <= i_data.coord_y;
            r_item.coord_z        <= i_data.coord_z;
        end
    end

endmodule
`default_nettype wire

>>> design/lcm_queue.sv
`default_nettype none
module lcm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_push_ready,
    input  wire lcm_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_pop,
    output lcm_pkg::t_item      o_item
);

    // two entry fifo
    lcm_pkg::t_item r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           do_push;
    logic           do_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_item       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

>>> design/lcm_back.sv
`default_nettype none
module lcm_back #(
    parameter int MAX_LABELS = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_pop,
    input  wire lcm_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output lcm_pkg::t_out_word  o_data
);

    localparam int CNT_W = $clog2(MAX_LABELS + 1);
    localparam int IW    = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int HW    = lcm_pkg::HUE_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    function automatic logic [HW-1:0] hue_next(input logic [HW-1:0] hue);
        logic [HW:0] sum;
        sum = {1'b0, hue} + {1'b0, lcm_pkg::HUE_STEP};
        if (sum >= lcm_pkg::HUE_WRAP) begin
            sum = sum - lcm_pkg::HUE_WRAP;
        end
        return sum[HW-1:0];
    endfunction

    function automatic t_rgb hsv_color(input logic [HW-1:0] hue);
        logic [2:0]    sector;
        logic [HW-1:0] base;
        logic [5:0]    rem;
        logic [5:0]    rem_inv;
        logic [9:0]    rise_x4;
        logic [9:0]    fall_x4;
        logic [7:0]    rise;
        logic [7:0]    fall;
        t_rgb          c;
        if      (hue >= 9'd300) begin sector = 3'd5; base = 9'd300; end
        else if (hue >= 9'd240) begin sector = 3'd4; base = 9'd240; end
        else if (hue >= 9'd180) begin sector = 3'd3; base = 9'd180; end
        else if (hue >= 9'd120) begin sector = 3'd2; base = 9'd120; end
        else if (hue >= 9'd60)  begin sector = 3'd1; base = 9'd60;  end
        else                    begin sector = 3'd0; base = 9'd0;   end
        rem     = 6'(hue - base);
        rem_inv = lcm_pkg::SECTOR_SPAN - rem;
        // 17*x = 16*x + x, then divide by four
        rise_x4 = {rem, 4'b0000} + {4'b0000, rem};
        fall_x4 = {rem_inv, 4'b0000} + {4'b0000, rem_inv};
        rise    = rise_x4[9:2];
        fall    = fall_x4[9:2];
        case (sector)
            3'd0:    c = '{8'd255, rise, 8'd0};
            3'd1:    c = '{fall, 8'd255, 8'd0};
            3'd2:    c = '{8'd0, 8'd255, rise};
            3'd3:    c = '{8'd0, fall, 8'd255};
            3'd4:    c = '{rise, 8'd0, 8'd255};
            default: c = '{8'd255, 8'd0, fall};
        endcase
        return c;
    endfunction

    logic [31:0]     r_mem [MAX_LABELS];
    logic [31:0]     r_rd_data;

    logic [1:0]      r_state,     n_state;
    logic [CNT_W-1:0] r_used,     n_used;
    logic [CNT_W-1:0] r_idx,      n_idx;
    logic [HW-1:0]   r_hue,       n_hue;
    logic [HW-1:0]   r_res_hue,   n_res_hue;
    logic            r_res_black, n_res_black;
    logic            r_res_full,  n_res_full;
    lcm_pkg::t_item  r_item,      n_item;
    logic            r_out_valid, n_out_valid;
    lcm_pkg::t_out_word r_out,    n_out;

    logic            we;
    logic [IW-1:0]   wr_addr;
    logic [31:0]     wr_data;
    logic [IW-1:0]   rd_addr;
    logic [CNT_W:0]  idx_inc;
    t_rgb            color;

    assign idx_inc = {1'b0, r_idx} + {{CNT_W{1'b0}}, 1'b1};
    assign color   = hsv_color(r_res_hue);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_idx       = r_idx;
        n_hue       = r_hue;
        n_res_hue   = r_res_hue;
        n_res_black = r_res_black;
        n_res_full  = r_res_full;
        n_item      = r_item;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        we          = 1'b0;
        wr_addr     = r_used[IW-1:0];
        wr_data     = r_item.label;
        rd_addr     = r_idx[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop       = 1'b1;
                    n_item      = i_item;
                    n_res_black = 1'b0;
                    n_res_full  = 1'b0;
                    if (i_item.start_of_cloud) begin
                        n_used = '0;
                    end
                    if (i_item.is_unlabeled) begin
                        n_res_black = 1'b1;
                        n_state     = S_DONE;
                    end else if (i_item.start_of_cloud || r_used == '0) begin
                        // empty table: first slot
                        we        = 1'b1;
                        wr_addr   = '0;
                        wr_data   = i_item.label;
                        n_used    = CNT_W'(1);
                        n_res_hue = lcm_pkg::HUE_STEP;
                        n_state   = S_DONE;
                    end else begin
                        n_idx   = '0;
                        n_hue   = lcm_pkg::HUE_STEP;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (idx_inc < {1'b0, r_used}) begin
                    rd_addr = idx_inc[IW-1:0];
                end
                if (r_rd_data == r_item.label) begin
                    n_res_hue = r_hue;
                    n_state   = S_DONE;
                end else if (idx_inc == {1'b0, r_used}) begin
                    if (r_used < CNT_W'(MAX_LABELS)) begin
                        we        = 1'b1;
                        n_used    = r_used + CNT_W'(1);
                        n_res_hue = hue_next(r_hue);
                    end else begin
                        n_res_black = 1'b1;
                        n_res_full  = 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    n_idx = idx_inc[CNT_W-1:0];
                    n_hue = hue_next(r_hue);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.out_x      = r_item.coord_x;
                    n_out.out_y      = r_item.coord_y;
                    n_out.out_z      = r_item.coord_z;
                    n_out.red        = r_res_black ? 8'd0 : color.red;
                    n_out.green      = r_res_black ? 8'd0 : color.green;
                    n_out.blue       = r_res_black ? 8'd0 : color.blue;
                    n_out.table_full = r_res_full;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_hue       <= n_hue;
        r_res_hue   <= n_res_hue;
        r_res_black <= n_res_black;
        r_res_full  <= n_res_full;
        r_item      <= n_item;
        r_out       <= n_out;
    end

    // label memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> design/label_to_color_mapper.sv
// Label colorizer for point clouds. Every input word yields exactly one result word, in order:
// the coordinate words pass through untouched and the point gets the color of its label within
// the current cloud. Label 0 is black. A new label takes the next slot n (from 1) and the HSV
// color at hue (n*77) mod 360; a label seen again reuses its slot color. With all MAX_LABELS
// slots taken a new label comes out black with table_full set. start_of_cloud empties the table
// before its own point. In the back end the search makes one compare per stored label, stopping
// at a match, through the single registered read port of the label memory; label 0 or an empty
// table skips the search. The front end and a two entry queue keep accepting words while a
// search runs, until both are full.
`default_nettype none
module label_to_color_mapper #(
    parameter int MAX_LABELS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire lcm_pkg::t_in_word  i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output lcm_pkg::t_out_word      o_data
);

    // front to queue
    logic           front_push;
    logic           queue_ready;
    lcm_pkg::t_item front_item;

    // queue to back
    logic           queue_valid;
    logic           back_pop;
    lcm_pkg::t_item queue_item;

    // input register, marks unlabeled words
    lcm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .o_push       (front_push),
        .i_push_ready (queue_ready),
        .o_item       (front_item)
    );

    // decouples acceptance from the label search
    lcm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_push),
        .o_push_ready (queue_ready),
        .i_item       (front_item),
        .o_valid      (queue_valid),
        .i_pop        (back_pop),
        .o_item       (queue_item)
    );

    // label table search, slot color and output register
    lcm_back #(
        .MAX_LABELS (MAX_LABELS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .o_pop   (back_pop),
        .i_item  (queue_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire
